// ----- hdl/dfwc_pkg.sv -----
// shared types and constants for the unique-entry id queue with removal
// no dependencies; used by dedup_fifo_with_cancel by scoped names
package dfwc_pkg;

   // queue geometry
   localparam int DEPTH    = 16;
   localparam int ID_W     = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_QUERY  = 3'd2,
      CMD_POP    = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE     = 3'd0,
      S_SCAN_RD  = 3'd1,
      S_SCAN_CMP = 3'd2,
      S_ACT      = 3'd3,
      S_SHIFT_RD = 3'd4,
      S_SHIFT_WR = 3'd5,
      S_RESP     = 3'd6
   } state_type;

endpackage

// ----- hdl/dfwc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module dfwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dedup_fifo_with_cancel.sv -----
// unique-entry id queue with push, remove from anywhere, query, pop and clear
// depends on dfwc_pkg and dfwc_ram
//
// steps: accept the start, scan each queued id through the slot ram's single read port
// (a read, then a compare; skipped when empty), decide, move each slot behind a gap one
// place toward the head (a read, then a write); the result is strobed for one cycle and
// busy is high until then. One command at a time, next start the cycle after the result.
// reset: synchronous; the queue is empty afterwards, slot contents are left as they are.
module dedup_fifo_with_cancel (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dfwc_pkg::CMD_W-1:0]     req_cmd,
   input  logic [31:0]                    req_user_id,
   output logic                           rsp_strobe,
   output logic [dfwc_pkg::STATUS_W-1:0]  rsp_status,
   output logic                           rsp_was_present,
   output logic                           rsp_head_valid,
   output logic [31:0]                    rsp_head_id,
   output logic [dfwc_pkg::CNT_W-1:0]     rsp_entry_count
);

   localparam int IDX_W = dfwc_pkg::IDX_W;
   localparam int CNT_W = dfwc_pkg::CNT_W;
   localparam int ID_W  = dfwc_pkg::ID_W;

   dfwc_pkg::state_type  state_ff, state_in;
   dfwc_pkg::cmd_type    cmd_ff, cmd_in;
   dfwc_pkg::status_type status_ff, status_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [ID_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic                 found_ff, found_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ID_W-1:0]      wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [ID_W-1:0]      rd_data;
   logic [CNT_W-1:0]     idx_next;
   logic                 more;
   logic                 do_shift;

   // slot storage, head at slot 0
   dfwc_ram #(
      .WIDTH (ID_W),
      .DEPTH (dfwc_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared compare against occupancy: is there a slot after idx
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign more     = idx_next < occ_ff;

   // does the decision step need a gap closed
   assign do_shift = ((cmd_ff == dfwc_pkg::CMD_REMOVE) && found_ff) ||
                     ((cmd_ff == dfwc_pkg::CMD_POP) && (occ_ff != '0));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfwc_pkg::S_IDLE: begin
            if (start) begin
               state_in = (occ_ff == '0) ? dfwc_pkg::S_ACT : dfwc_pkg::S_SCAN_RD;
            end
         end
         dfwc_pkg::S_SCAN_RD:  state_in = dfwc_pkg::S_SCAN_CMP;
         dfwc_pkg::S_SCAN_CMP: state_in = more ? dfwc_pkg::S_SCAN_RD : dfwc_pkg::S_ACT;
         dfwc_pkg::S_ACT:      state_in = do_shift ? dfwc_pkg::S_SHIFT_RD : dfwc_pkg::S_RESP;
         dfwc_pkg::S_SHIFT_RD: state_in = more ? dfwc_pkg::S_SHIFT_WR : dfwc_pkg::S_RESP;
         dfwc_pkg::S_SHIFT_WR: state_in = dfwc_pkg::S_SHIFT_RD;
         dfwc_pkg::S_RESP:     state_in = dfwc_pkg::S_IDLE;
         default:              state_in = dfwc_pkg::S_IDLE;
      endcase
   end

   // datapath and ram control per state
   always_comb begin
      cmd_in    = cmd_ff;
      status_in = status_ff;
      id_in     = id_ff;
      head_in   = head_ff;
      occ_in    = occ_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = id_ff;
      rd_addr   = idx_ff;
      case (state_ff)
         dfwc_pkg::S_IDLE: begin
            if (start) begin
               cmd_in   = dfwc_pkg::cmd_type'(req_cmd);
               id_in    = req_user_id[ID_W-1:0];
               idx_in   = '0;
               pos_in   = '0;
               found_in = 1'b0;
            end
         end
         // compare one occupied slot per pass
         dfwc_pkg::S_SCAN_CMP: begin
            if (rd_data == id_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
            end
            if (more) begin
               idx_in = idx_next[IDX_W-1:0];
            end
         end
         // act on the command once membership is known
         dfwc_pkg::S_ACT: begin
            status_in = dfwc_pkg::ST_OK;
            case (cmd_ff)
               dfwc_pkg::CMD_PUSH: begin
                  if (found_ff) begin
                     status_in = dfwc_pkg::ST_DUP;
                  end else if (occ_ff == CNT_W'(dfwc_pkg::DEPTH)) begin
                     status_in = dfwc_pkg::ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = occ_ff[IDX_W-1:0];
                     wr_data = id_ff;
                     occ_in  = occ_ff + CNT_W'(1);
                     if (occ_ff == '0) begin
                        head_in = id_ff;
                     end
                  end
               end
               dfwc_pkg::CMD_REMOVE: begin
                  if (found_ff) begin
                     idx_in = pos_ff;
                  end else begin
                     status_in = dfwc_pkg::ST_NOTFOUND;
                  end
               end
               dfwc_pkg::CMD_QUERY: begin
                  if (!found_ff) begin
                     status_in = dfwc_pkg::ST_NOTFOUND;
                  end
               end
               dfwc_pkg::CMD_POP: begin
                  if (occ_ff == '0) begin
                     status_in = dfwc_pkg::ST_EMPTY;
                  end else begin
                     idx_in = '0;
                  end
               end
               dfwc_pkg::CMD_CLEAR: begin
                  occ_in = '0;
               end
               default: begin
                  status_in = dfwc_pkg::ST_OK;
               end
            endcase
         end
         // fetch the slot behind the gap, or finish the removal
         dfwc_pkg::S_SHIFT_RD: begin
            rd_addr = idx_next[IDX_W-1:0];
            if (!more) begin
               occ_in = occ_ff - CNT_W'(1);
            end
         end
         // move it one place toward the head
         dfwc_pkg::S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (idx_ff == '0) begin
               head_in = rd_data;
            end
            idx_in = idx_next[IDX_W-1:0];
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfwc_pkg::S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      head_ff   <= head_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
   end

   // result transfer
   assign busy            = (state_ff != dfwc_pkg::S_IDLE);
   assign rsp_strobe      = (state_ff == dfwc_pkg::S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_was_present = found_ff;
   assign rsp_head_valid  = (occ_ff != '0);
   assign rsp_head_id     = (occ_ff != '0) ? 32'(head_ff) : 32'd0;
   assign rsp_entry_count = occ_ff;

endmodule
